[rtl/spr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants of the servo position ramp.
package spr_pkg;

   // Field and state widths
   localparam int PULSE_W    = 12;
   localparam int POS_W      = 20;
   localparam int FRAC_W     = 8;
   localparam int ACC_W      = 24;
   localparam int NORM_W     = 16;
   localparam int SPEED_W    = 17;
   localparam int GAIN_W     = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 3;

   // Derived arithmetic widths
   localparam int ERR_W    = POS_W + 1;
   localparam int PROD_P_W = ERR_W + GAIN_W + 1;
   localparam int PROD_I_W = ACC_W + GAIN_W + 1;
   localparam int PSUM_W   = PROD_I_W + 1;
   localparam int STEP_W   = PSUM_W - FRAC_W;

   // Controller constants, Q.8 in 1/256 tick
   localparam logic [POS_W-1:0] INTEGRAL_WINDOW = 20'd5120;
   localparam logic [ACC_W-2:0] INTEGRAL_CLAMP  = 23'd25600;
   localparam logic [15:0]      SLEW_STEP       = 16'd26;
   localparam logic [15:0]      MAX_STEP        = 16'd1280;
   localparam logic [POS_W-1:0] POS_MAX         = {POS_W{1'b1}};
   localparam logic [ACC_W-2:0] SLEW_LIM        = {(ACC_W-1){1'b1}};

   // Register reset values
   localparam logic [PULSE_W-1:0] PULSE_LOWER_RST = 12'd150;
   localparam logic [PULSE_W-1:0] PULSE_UPPER_RST = 12'd600;
   localparam logic [SPEED_W-1:0] SPEED_RST       = 17'h10000;
   localparam int                 MID_RST         =
      (int'(PULSE_LOWER_RST) + int'(PULSE_UPPER_RST)) / 2;
   localparam logic [POS_W-1:0]   POS_RST         = POS_W'(MID_RST * 256);

   // Default queue depths
   localparam int REQ_QUEUE_DEPTH_DEF = 2;
   localparam int RSP_QUEUE_DEPTH_DEF = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_LOWER  = 3'd0,
      CSR_PULSE_UPPER  = 3'd1,
      CSR_REVERSED_DIR = 3'd2,
      CSR_USE_PI       = 3'd3,
      CSR_USE_SLEW     = 3'd4,
      CSR_SPEED_FRAC   = 3'd5,
      CSR_GAIN_P       = 3'd6,
      CSR_GAIN_I       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_lower;
      logic [PULSE_W-1:0] pulse_upper;
      logic               reversed_dir;
      logic               use_pi;
      logic               use_slew;
      logic [SPEED_W-1:0] speed_frac;
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
   } cfg_type;

   typedef struct packed {
      logic                     mode;
      logic signed [NORM_W-1:0] target_norm;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_value;
      logic               pulse_write;
      logic               at_target;
   } rsp_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [POS_W-1:0] target;
   } cmd_type;

   typedef enum logic {
      BACK_EXEC   = 1'b0,
      BACK_FINISH = 1'b1
   } back_state_type;

   typedef struct packed {
      logic finish;
      logic cmd_pop;
      logic rsp_push;
   } back_status_type;

endpackage

[rtl/spr_fifo.sv]
`timescale 1ns / 1ps
// Small register queue used between the front, the back and the result port.
module spr_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   // DEPTH of two or more
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/spr_front.sv]
`timescale 1ns / 1ps
// Front end: classifies request beats and maps set-target positions into Q12.8.
module spr_front (
   input  spr_pkg::req_type req_data,
   input  spr_pkg::cfg_type cfg,
   output spr_pkg::cmd_type cmd
);
   import spr_pkg::*;

   localparam int SCALED_W = NORM_W + PULSE_W + 2;
   localparam int OFFSET_W = SCALED_W - 7;
   localparam int SUM_W    = POS_W + 4;

   logic [PULSE_W:0]          limit_sum;
   logic [PULSE_W-1:0]        mid;
   logic signed [PULSE_W:0]   span;
   logic signed [NORM_W:0]    norm_raw;
   logic signed [NORM_W:0]    norm;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [OFFSET_W-1:0] offset;
   logic signed [SUM_W-1:0]   target_sum;
   logic [POS_W-1:0]          target;

   always_comb begin
      limit_sum = {1'b0, cfg.pulse_lower} + {1'b0, cfg.pulse_upper};
      mid       = limit_sum[PULSE_W:1];
      span      = $signed({1'b0, mid}) - $signed({1'b0, cfg.pulse_lower});
      norm_raw  = {req_data.target_norm[NORM_W-1], req_data.target_norm};
      // negate when reversed; -1.0 turns into +1.0 exactly
      norm      = cfg.reversed_dir ? -norm_raw : norm_raw;
      scaled    = norm * span;
      offset    = OFFSET_W'(scaled >>> 7);
      target_sum = $signed({{(SUM_W-POS_W){1'b0}}, mid, {FRAC_W{1'b0}}}) + SUM_W'(offset);
      priority if (target_sum[SUM_W-1]) begin
         target = '0;
      end else if (|target_sum[SUM_W-2:POS_W]) begin
         target = POS_MAX;
      end else begin
         target = target_sum[POS_W-1:0];
      end
      cmd.kind   = req_data.mode ? CMD_SET : CMD_TICK;
      cmd.target = target;
   end

endmodule

[rtl/spr_back.sv]
`timescale 1ns / 1ps
// Back end: holds position, target and controller state and executes commands.
module spr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  spr_pkg::cfg_type        cfg,
   input  spr_pkg::cmd_type        cmd,
   input  logic                    cmd_valid,
   input  logic                    rsp_full,
   output spr_pkg::rsp_type        rsp,
   output spr_pkg::back_status_type status
);
   import spr_pkg::*;

   back_state_type            state_ff, state_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic [POS_W-1:0]          target_ff, target_in;
   logic signed [ACC_W-1:0]   integral_ff, integral_in;
   logic signed [ACC_W-1:0]   slew_ff, slew_in;
   logic signed [PROD_P_W-1:0] prod_p_ff, prod_p;
   logic signed [PROD_I_W-1:0] prod_i_ff, prod_i;
   logic                      prod_load;

   logic signed [ERR_W-1:0]   err;
   logic                      err_neg;
   logic [ERR_W-1:0]          abs_err;
   logic                      at_pos;
   logic signed [ACC_W:0]     integ_sum;
   logic signed [ACC_W:0]     integ_lim;
   logic signed [ACC_W-1:0]   integ_next;
   logic signed [PSUM_W-1:0]  pi_sum;
   logic signed [STEP_W-1:0]  pi_step;
   logic [31:0]               const_prod;
   logic signed [STEP_W-1:0]  const_pos;
   logic signed [STEP_W-1:0]  const_step;
   logic signed [STEP_W-1:0]  raw_step;
   logic [STEP_W-1:0]         abs_raw;
   logic [ACC_W-1:0]          abs_slew;
   logic signed [STEP_W-1:0]  step;
   logic [STEP_W-1:0]         abs_step;
   logic signed [ACC_W:0]     slew_sum;
   logic signed [ACC_W:0]     slew_lim;
   logic signed [ACC_W-1:0]   slew_next;
   logic signed [STEP_W:0]    pos_sum;
   logic [POS_W-1:0]          moved_pos;
   logic [POS_W-1:0]          new_pos;
   logic                      emit, write;

   // Error and integral
   always_comb begin
      err       = $signed({1'b0, target_ff}) - $signed({1'b0, position_ff});
      err_neg   = err[ERR_W-1];
      abs_err   = err_neg ? ERR_W'(-err) : ERR_W'(err);
      at_pos    = (position_ff == target_ff);
      integ_sum = (ACC_W+1)'(integral_ff) + (ACC_W+1)'(err);
      integ_lim = $signed({2'b00, INTEGRAL_CLAMP});
      priority if (abs_err > {1'b0, INTEGRAL_WINDOW}) begin
         integ_next = '0;
      end else if (integ_sum > integ_lim) begin
         integ_next = ACC_W'(integ_lim);
      end else if (integ_sum < -integ_lim) begin
         integ_next = ACC_W'(-integ_lim);
      end else begin
         integ_next = ACC_W'(integ_sum);
      end
      prod_p = err * $signed({1'b0, cfg.gain_p});
      prod_i = integ_next * $signed({1'b0, cfg.gain_i});
   end

   // Step select, slew limit and position update
   always_comb begin
      pi_sum     = PSUM_W'(prod_p_ff) + PSUM_W'(prod_i_ff);
      pi_step    = STEP_W'(pi_sum >>> FRAC_W);
      const_prod = MAX_STEP * cfg.speed_frac[SPEED_W-2:0];
      const_pos  = $signed(STEP_W'(const_prod[31:16]));
      const_step = err_neg ? -const_pos : const_pos;
      raw_step   = (state_ff == BACK_FINISH) ? pi_step : const_step;
      abs_raw    = raw_step[STEP_W-1] ? STEP_W'(-raw_step) : STEP_W'(raw_step);
      abs_slew   = slew_ff[ACC_W-1] ? ACC_W'(-slew_ff) : ACC_W'(slew_ff);
      if (cfg.use_slew && (STEP_W'(abs_slew) < abs_raw)) begin
         step = STEP_W'(slew_ff);
      end else begin
         step = raw_step;
      end
      abs_step = step[STEP_W-1] ? STEP_W'(-step) : STEP_W'(step);

      slew_lim = $signed({2'b00, SLEW_LIM});
      slew_sum = (ACC_W+1)'(slew_ff) +
                 (err_neg ? -$signed({9'b0, SLEW_STEP}) : $signed({9'b0, SLEW_STEP}));
      priority if (slew_sum > slew_lim) begin
         slew_next = ACC_W'(slew_lim);
      end else if (slew_sum < -slew_lim) begin
         slew_next = ACC_W'(-slew_lim);
      end else begin
         slew_next = ACC_W'(slew_sum);
      end

      pos_sum = $signed({{(STEP_W+1-POS_W){1'b0}}, position_ff}) + (STEP_W+1)'(step);
      priority if (pos_sum[STEP_W]) begin
         moved_pos = '0;
      end else if (|pos_sum[STEP_W-1:POS_W]) begin
         moved_pos = POS_MAX;
      end else begin
         moved_pos = pos_sum[POS_W-1:0];
      end
      // snap onto the target rather than overshoot it
      new_pos = (STEP_W'(abs_err) < abs_step) ? target_ff : moved_pos;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      position_in = position_ff;
      target_in   = target_ff;
      integral_in = integral_ff;
      slew_in     = slew_ff;
      prod_load   = 1'b0;
      emit        = 1'b0;
      write       = 1'b0;
      unique case (state_ff)
         BACK_EXEC: begin
            if (cmd_valid && !rsp_full) begin
               unique case (cmd.kind)
                  CMD_SET: begin
                     target_in   = cmd.target;
                     integral_in = '0;
                     slew_in     = '0;
                     emit        = 1'b1;
                  end
                  CMD_TICK: begin
                     priority if (at_pos) begin
                        emit = 1'b1;
                     end else if (cfg.speed_frac[SPEED_W-1]) begin
                        position_in = target_ff;
                        write       = 1'b1;
                        emit        = 1'b1;
                     end else if (cfg.use_pi) begin
                        integral_in = integ_next;
                        prod_load   = 1'b1;
                        state_in    = BACK_FINISH;
                     end else begin
                        position_in = new_pos;
                        if (cfg.use_slew) begin
                           slew_in = slew_next;
                        end
                        write = 1'b1;
                        emit  = 1'b1;
                     end
                  end
               endcase
            end
         end
         BACK_FINISH: begin
            if (!rsp_full) begin
               position_in = new_pos;
               if (cfg.use_slew) begin
                  slew_in = slew_next;
               end
               write    = 1'b1;
               emit     = 1'b1;
               state_in = BACK_EXEC;
            end
         end
      endcase

      rsp.pulse_value = position_in[POS_W-1:FRAC_W];
      rsp.pulse_write = write;
      rsp.at_target   = (position_in == target_in);
      status.finish   = (state_ff == BACK_FINISH);
      status.cmd_pop  = emit;
      status.rsp_push = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_EXEC;
         position_ff <= POS_RST;
         target_ff   <= POS_RST;
         integral_ff <= '0;
         slew_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         position_ff <= position_in;
         target_ff   <= target_in;
         integral_ff <= integral_in;
         slew_ff     <= slew_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_p_ff <= prod_p;
         prod_i_ff <= prod_i;
      end
   end

endmodule

[rtl/servo_position_ramp_pi_slew.sv]
`timescale 1ns / 1ps
// Top level of the servo position ramp with PI step and slew limit.
//
// Usage: request beats enter through req_push / req_full. A beat with mode 1
// sets a new target from the Q1.15 normalised position; a beat with mode 0 is
// a control tick that moves the Q12.8 position towards the target. Every
// request beat yields exactly one result beat, in order, on rsp_data while
// rsp_empty is low; take it with rsp_pop.
// Registers are written through csr_write_en / csr_index / csr_wdata with no
// wait; write them only while no beat is in flight.
// A result passes through the command queue and the result queue; a PI tick's
// step also goes through one registered multiply stage before it is added to
// the position.
// Throughput: one beat per cycle while the result queue has room; a PI tick
// also takes the finish state, as the position feeds back through that stage.
// The front end maps targets and queues commands; the back end works through
// the command queue, so a stalled result port fills the result queue, then
// the command queue, and only then raises req_full.
// Reset (synchronous, active high) empties both queues, loads the register
// reset values and places position and target at the mid-pulse point.
module servo_position_ramp_pi_slew #(
   parameter int REQ_QUEUE_DEPTH = spr_pkg::REQ_QUEUE_DEPTH_DEF,
   parameter int RSP_QUEUE_DEPTH = spr_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  spr_pkg::req_type                    req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output spr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  spr_pkg::csr_index_type              csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import spr_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cfg_type         cfg_ff, cfg_in;
   cmd_type         front_cmd;
   cmd_type         back_cmd;
   logic [CMD_W-1:0] cmd_bits;
   logic            cmd_empty;
   logic            cmd_valid;
   rsp_type         back_rsp;
   logic [RSP_W-1:0] rsp_bits;
   logic            rsp_full;
   back_status_type status;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PULSE_LOWER:  cfg_in.pulse_lower  = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_UPPER:  cfg_in.pulse_upper  = csr_wdata[PULSE_W-1:0];
            CSR_REVERSED_DIR: cfg_in.reversed_dir = csr_wdata[0];
            CSR_USE_PI:       cfg_in.use_pi       = csr_wdata[0];
            CSR_USE_SLEW:     cfg_in.use_slew     = csr_wdata[0];
            CSR_SPEED_FRAC:   cfg_in.speed_frac   = csr_wdata[SPEED_W-1:0];
            CSR_GAIN_P:       cfg_in.gain_p       = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:       cfg_in.gain_i       = csr_wdata[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_lower  <= PULSE_LOWER_RST;
         cfg_ff.pulse_upper  <= PULSE_UPPER_RST;
         cfg_ff.reversed_dir <= 1'b0;
         cfg_ff.use_pi       <= 1'b0;
         cfg_ff.use_slew     <= 1'b0;
         cfg_ff.speed_frac   <= SPEED_RST;
         cfg_ff.gain_p       <= '0;
         cfg_ff.gain_i       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify and map
   spr_front u_front (
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (front_cmd)
   );

   // Command queue between front and back
   spr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (REQ_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_cmd),
      .full  (req_full),
      .pop   (status.cmd_pop),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign back_cmd  = cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

   // Back end: execute commands against the servo state
   spr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (back_cmd),
      .cmd_valid (cmd_valid),
      .rsp_full  (rsp_full),
      .rsp       (back_rsp),
      .status    (status)
   );

   // Result queue decouples the back end from a stalled receiver
   spr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (status.rsp_push),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

   // The PI finish state only follows a PI tick that is not a full-speed jump
   a_finish_pi : assert property (@(posedge clock) disable iff (reset)
      status.finish |-> (cfg_ff.use_pi && !cfg_ff.speed_frac[SPEED_W-1]))
      else $error("PI finish cycle without PI mode");

   // With room for the result, the PI tick completes in the finish state, which the back end then leaves
   a_finish_leaves : assert property (@(posedge clock) disable iff (reset)
      (status.finish && !rsp_full) |=> !status.finish)
      else $error("PI finish cycle did not complete");

   // Every result beat consumes a queued command
   a_rsp_has_cmd : assert property (@(posedge clock) disable iff (reset)
      status.rsp_push |-> (cmd_valid && !rsp_full))
      else $error("result pushed without a command or queue space");

endmodule
